// ===== rtl/smbs_pkg.sv =====
// Shared types, register indexes and constants for the SPI byte shifter.
package smbs_pkg;

    localparam int CMD_QUEUE_DEPTH = 2;
    localparam int RES_QUEUE_DEPTH = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLED     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPI_MODE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MOSI_CONN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MISO_CONN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 3'd4;

    localparam logic [7:0]  TX_IDLE_BYTE    = 8'hFF;
    localparam logic [2:0]  BIT_MSB         = 3'd7;
    localparam logic [15:0] HALF_PERIOD_RST = 16'd1;

    typedef struct packed {
        logic       is_start;
        logic [7:0] load_byte;
        logic       last;
        logic       miso;
    } t_cmd;

    typedef struct packed {
        logic       sck_level;
        logic       mosi_level;
        logic [7:0] rx_byte;
        logic       byte_done;
        logic       transfer_end;
        logic       busy_res;
        logic       rejected;
    } t_result;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

endpackage

// ===== rtl/smbs_queue.sv =====
// Small register FIFO used between the front, the shift engine and the result port.
module smbs_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = smbs_pkg::CMD_QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        unique case ({do_push, do_pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_pop_only_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_pop && !do_push) |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("queue count not decremented on pop");

endmodule

// ===== rtl/smbs_front.sv =====
// Front end: takes input beats, decodes them into commands and queues them.
module smbs_front #(
    parameter int CMD_DEPTH = smbs_pkg::CMD_QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_full,
    input  logic           i_action,
    input  logic [7:0]     i_tx_byte,
    input  logic           i_has_tx,
    input  logic           i_last_byte,
    input  logic           i_miso_level,
    input  logic           i_cmd_pop,
    output smbs_pkg::t_cmd o_cmd,
    output logic           o_cmd_valid
);
    smbs_pkg::t_cmd in_cmd;
    logic           cmd_empty;
    logic [$bits(smbs_pkg::t_cmd)-1:0] head_bits;

    always_comb begin
        in_cmd.is_start  = i_action;
        // no transmit data: send all ones
        in_cmd.load_byte = i_has_tx ? i_tx_byte : smbs_pkg::TX_IDLE_BYTE;
        in_cmd.last      = i_last_byte;
        in_cmd.miso      = i_miso_level;
    end

    smbs_queue #(
        .WIDTH ($bits(smbs_pkg::t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (in_cmd),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_data  (head_bits),
        .o_empty (cmd_empty)
    );

    assign o_cmd       = smbs_pkg::t_cmd'(head_bits);
    assign o_cmd_valid = !cmd_empty;

endmodule

// ===== rtl/smbs_back.sv =====
// Back end: configuration registers, SPI shift engine and result queue.
module smbs_back #(
    parameter int RES_DEPTH = smbs_pkg::RES_QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  smbs_pkg::t_cfg_wr i_cfg,
    input  smbs_pkg::t_cmd    i_cmd,
    input  logic              i_cmd_valid,
    output logic              o_cmd_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output smbs_pkg::t_result o_res
);
    // configuration
    logic        r_enabled, n_enabled;
    logic [1:0]  r_spi_mode, n_spi_mode;
    logic        r_mosi_conn, n_mosi_conn;
    logic        r_miso_conn, n_miso_conn;
    logic [15:0] r_half_period, n_half_period;

    // engine state
    logic [7:0]  r_out_shift, n_out_shift;
    logic [7:0]  r_in_shift, n_in_shift;
    logic [2:0]  r_bit_index, n_bit_index;
    logic        r_second_half, n_second_half;
    logic [15:0] r_tick_count, n_tick_count;
    logic        r_active, n_active;
    logic        r_final, n_final;
    logic        r_sck, n_sck;
    logic        r_mosi, n_mosi;

    smbs_pkg::t_result res;
    logic              res_full;
    logic              consume;
    logic              cpol, cpha;
    logic [15:0]       hp;
    logic [16:0]       tick_next;
    logic [$bits(smbs_pkg::t_result)-1:0] res_bits;

    assign consume   = i_cmd_valid && !res_full;
    assign o_cmd_pop = consume;
    assign cpol      = r_spi_mode[1];
    assign cpha      = r_spi_mode[0];
    assign hp        = (r_half_period == '0) ? 16'd1 : r_half_period;
    assign tick_next = {1'b0, r_tick_count} + 17'd1;

    always_comb begin
        n_enabled     = r_enabled;
        n_spi_mode    = r_spi_mode;
        n_mosi_conn   = r_mosi_conn;
        n_miso_conn   = r_miso_conn;
        n_half_period = r_half_period;
        n_out_shift   = r_out_shift;
        n_in_shift    = r_in_shift;
        n_bit_index   = r_bit_index;
        n_second_half = r_second_half;
        n_tick_count  = r_tick_count;
        n_active      = r_active;
        n_final       = r_final;
        n_sck         = r_sck;
        n_mosi        = r_mosi;

        res.rx_byte      = '0;
        res.byte_done    = 1'b0;
        res.transfer_end = 1'b0;
        res.rejected     = 1'b0;

        if (consume) begin
            if (i_cmd.is_start) begin
                if (r_active || !r_enabled) begin
                    res.rejected = 1'b1;
                end else begin
                    n_out_shift   = i_cmd.load_byte;
                    n_in_shift    = '0;
                    n_bit_index   = smbs_pkg::BIT_MSB;
                    n_second_half = 1'b0;
                    n_tick_count  = '0;
                    n_active      = 1'b1;
                    n_final       = i_cmd.last;
                    if (cpha) begin
                        n_sck = ~cpol;
                    end
                    n_mosi = i_cmd.load_byte[smbs_pkg::BIT_MSB];
                end
            end else if (r_active) begin
                if (tick_next < {1'b0, hp}) begin
                    n_tick_count = tick_next[15:0];
                end else begin
                    n_tick_count = '0;
                    if (!r_second_half) begin
                        n_sck         = cpha ? cpol : ~cpol;
                        n_second_half = 1'b1;
                    end else begin
                        if (r_miso_conn && i_cmd.miso) begin
                            n_in_shift[r_bit_index] = 1'b1;
                        end
                        if (!cpha) begin
                            n_sck = cpol;
                        end
                        n_second_half = 1'b0;
                        if (r_bit_index == '0) begin
                            res.byte_done    = 1'b1;
                            res.rx_byte      = n_in_shift;
                            res.transfer_end = r_final;
                            n_active         = 1'b0;
                            n_bit_index      = smbs_pkg::BIT_MSB;
                        end else begin
                            n_bit_index = r_bit_index - 3'd1;
                            if (cpha) begin
                                n_sck = ~cpol;
                            end
                            n_mosi = r_out_shift[n_bit_index];
                        end
                    end
                end
            end
        end

        if (i_cfg.we) begin
            unique case (i_cfg.idx)
                smbs_pkg::REG_ENABLED:     n_enabled     = i_cfg.data[0];
                smbs_pkg::REG_SPI_MODE: begin
                    n_spi_mode = i_cfg.data[1:0];
                    // idle SCK follows the new polarity at once
                    if (!r_active) begin
                        n_sck = i_cfg.data[1];
                    end
                end
                smbs_pkg::REG_MOSI_CONN:   n_mosi_conn   = i_cfg.data[0];
                smbs_pkg::REG_MISO_CONN:   n_miso_conn   = i_cfg.data[0];
                smbs_pkg::REG_HALF_PERIOD: n_half_period = i_cfg.data[15:0];
                default: ;
            endcase
        end

        res.sck_level  = n_sck;
        res.mosi_level = n_mosi & r_mosi_conn;
        res.busy_res   = n_active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled     <= 1'b0;
            r_spi_mode    <= 2'd0;
            r_mosi_conn   <= 1'b0;
            r_miso_conn   <= 1'b0;
            r_half_period <= smbs_pkg::HALF_PERIOD_RST;
            r_out_shift   <= '0;
            r_in_shift    <= '0;
            r_bit_index   <= smbs_pkg::BIT_MSB;
            r_second_half <= 1'b0;
            r_tick_count  <= '0;
            r_active      <= 1'b0;
            r_final       <= 1'b0;
            r_sck         <= 1'b0;
            r_mosi        <= 1'b0;
        end else begin
            r_enabled     <= n_enabled;
            r_spi_mode    <= n_spi_mode;
            r_mosi_conn   <= n_mosi_conn;
            r_miso_conn   <= n_miso_conn;
            r_half_period <= n_half_period;
            r_out_shift   <= n_out_shift;
            r_in_shift    <= n_in_shift;
            r_bit_index   <= n_bit_index;
            r_second_half <= n_second_half;
            r_tick_count  <= n_tick_count;
            r_active      <= n_active;
            r_final       <= n_final;
            r_sck         <= n_sck;
            r_mosi        <= n_mosi;
        end
    end

    smbs_queue #(
        .WIDTH ($bits(smbs_pkg::t_result)),
        .DEPTH (RES_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (consume),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (i_pop),
        .o_data  (res_bits),
        .o_empty (o_empty)
    );

    assign o_res = smbs_pkg::t_result'(res_bits);

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> (!r_second_half && r_tick_count == '0
                       && r_bit_index == smbs_pkg::BIT_MSB))
        else $error("engine idle with stale bit state");

    a_start_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && i_cmd.is_start && !r_active && r_enabled)
        |=> (r_active && r_bit_index == smbs_pkg::BIT_MSB))
        else $error("accepted start did not begin a byte");

    a_done_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && res.byte_done) |=> (!r_active && !r_second_half))
        else $error("engine still busy after finishing a byte");

endmodule

// ===== rtl/spi_master_byte_shifter.sv =====
// Beats pass the command FIFO and shift engine; the result FIFO head drives the result ports.
// Throughput: one beat per cycle in and out while the result FIFO is not full.
// Each beat yields exactly one result beat; the rate is set by the shift engine.
// Each FIFO holds CMD_DEPTH / RES_DEPTH beats and stalls on its own when full.
// Reset: synchronous, active low; clears FIFOs, engine state and config to defaults.
module spi_master_byte_shifter #(
    parameter int CMD_DEPTH = smbs_pkg::CMD_QUEUE_DEPTH,
    parameter int RES_DEPTH = smbs_pkg::RES_QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic                            i_action,
    input  logic [7:0]                      i_tx_byte,
    input  logic                            i_has_tx,
    input  logic                            i_last_byte,
    input  logic                            i_miso_level,
    output logic                            empty,
    input  logic                            pop,
    output logic                            o_sck_level,
    output logic                            o_mosi_level,
    output logic [7:0]                      o_rx_byte,
    output logic                            o_byte_done,
    output logic                            o_transfer_end,
    output logic                            o_busy_res,
    output logic                            o_rejected,
    input  logic                            i_cfg_we,
    input  logic [smbs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [smbs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    smbs_pkg::t_cmd    cmd;
    smbs_pkg::t_result res;
    smbs_pkg::t_cfg_wr cfg;
    logic              cmd_valid;
    logic              cmd_pop;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    smbs_front #(
        .CMD_DEPTH (CMD_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_action     (i_action),
        .i_tx_byte    (i_tx_byte),
        .i_has_tx     (i_has_tx),
        .i_last_byte  (i_last_byte),
        .i_miso_level (i_miso_level),
        .i_cmd_pop    (cmd_pop),
        .o_cmd        (cmd),
        .o_cmd_valid  (cmd_valid)
    );

    smbs_back #(
        .RES_DEPTH (RES_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_res       (res)
    );

    assign o_sck_level    = res.sck_level;
    assign o_mosi_level   = res.mosi_level;
    assign o_rx_byte      = res.rx_byte;
    assign o_byte_done    = res.byte_done;
    assign o_transfer_end = res.transfer_end;
    assign o_busy_res     = res.busy_res;
    assign o_rejected     = res.rejected;

endmodule
